>>> hw/rtl/ppcp_pkg.sv
package ppcp_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int NUM_TERMS      = 27;

  typedef enum logic [2:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_CENTER_Z   = 3'd2,
    REG_RADIUS     = 3'd3,
    REG_POTENTIAL  = 3'd4,
    REG_PERIOD_X   = 3'd5,
    REG_PERIOD_Y   = 3'd6,
    REG_PERIOD_Z   = 3'd7
  } cfg_reg_t;

  // offset code per axis: minus one period, none, plus one period
  typedef enum logic [1:0] {
    OFS_MINUS = 2'd0,
    OFS_NONE  = 2'd1,
    OFS_PLUS  = 2'd2
  } ofs_t;

  typedef struct packed {
    logic vld;
    logic add;     // face and corner images add, centre and edges subtract
    logic first;
    logic last;
    logic centre;
    logic interior;
    logic sat;
  } term_tag_t;

endpackage

>>> hw/rtl/periodic_point_charge_potential.sv
// Channel  | Handshake           | Payload
// in       | in_valid / in_stall | in_point_x, in_point_y, in_point_z
// out      | out_valid/out_stall | out_potential, out_saturated
// cfg      | cfg_we              | cfg_index, cfg_data
//
// A new point is taken only once the previous one has issued all 27 terms: the single term
// pipeline (square, digit by digit square root, restoring divide) takes one image term per
// cycle while it is not frozen by a held result.
// rst_n is synchronous: it clears all valid bits and loads the default registers.
// out_stall holds the result register; the pipeline freezes only when the next
// result is ready behind a held one. Nothing is lost.
module periodic_point_charge_potential #(
  parameter int COORD_BITS = ppcp_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = ppcp_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] in_point_x,
  input  logic [COORD_BITS-1:0] in_point_y,
  input  logic [COORD_BITS-1:0] in_point_z,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_potential,
  output logic                  out_saturated,
  input  logic                  cfg_we,
  input  ppcp_pkg::cfg_reg_t    cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data
);
  import ppcp_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int FB   = FRAC_BITS;
  localparam int BW   = CW + 1;
  localparam int DW   = CW + 2;
  localparam int MW   = CW + 1;
  localparam int SQW  = 2 * MW;
  localparam int RW   = CW + 2;
  localparam int SW2  = 2 * RW;
  localparam int RMW  = RW + 2;
  localparam int NB   = 2 * FB + 1;
  localparam int QX   = (NB > CW - 1) ? NB : CW - 1;
  localparam int CPW  = (RW + CW > 2 * FB + 2) ? RW + CW : 2 * FB + 2;
  localparam int ACW  = CW + 5;
  localparam int SMW  = CW + 4;
  localparam int PRW  = 2 * CW - 1 - FB;
  localparam int PL   = PRW / 2;
  localparam int PH   = PRW - PL;
  localparam int PFW  = PRW + SMW;
  localparam logic [CW-2:0] QMAX = {(CW-1){1'b1}};

  // configuration
  logic [CW-1:0] cen_x_r, cen_y_r, cen_z_r, pot_r;
  logic [CW-2:0] rad_r, per_x_r, per_y_r, per_z_r;
  logic [2*CW-3:0] rr_r;
  logic [PRW-1:0]  pr_r;
  logic [CW-1:0]   pmag;
  logic [2*CW-2:0] prf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cen_x_r <= '0;
      cen_y_r <= '0;
      cen_z_r <= '0;
      rad_r   <= (CW-1)'(1) << FB;
      pot_r   <= CW'(10) << FB;
      per_x_r <= (CW-1)'(10) << FB;
      per_y_r <= (CW-1)'(10) << FB;
      per_z_r <= (CW-1)'(10) << FB;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X:  cen_x_r <= cfg_data;
        REG_CENTER_Y:  cen_y_r <= cfg_data;
        REG_CENTER_Z:  cen_z_r <= cfg_data;
        REG_RADIUS:    rad_r   <= cfg_data[CW-2:0];
        REG_POTENTIAL: pot_r   <= cfg_data;
        REG_PERIOD_X:  per_x_r <= cfg_data[CW-2:0];
        REG_PERIOD_Y:  per_y_r <= cfg_data[CW-2:0];
        REG_PERIOD_Z:  per_z_r <= cfg_data[CW-2:0];
        default: ;
      endcase
    end
  end

  // derived constants, settled while the block is idle
  assign pmag = pot_r[CW-1] ? (~pot_r + CW'(1)) : pot_r;
  assign prf  = pmag * rad_r;

  always_ff @(posedge clk) begin
    rr_r <= rad_r * rad_r;
    pr_r <= prf[2*CW-2:FB];
  end

  logic en;
  logic out_valid_r;

  // term sequencer
  logic          seq_busy_r;
  logic [1:0]    ki_r, kj_r, kk_r;
  logic [BW-1:0] bx_r, by_r, bz_r;
  logic          seq_last, in_take;

  assign seq_last = (ki_r == OFS_PLUS) && (kj_r == OFS_PLUS) && (kk_r == OFS_PLUS);
  assign in_stall = !en || (seq_busy_r && !seq_last);
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_busy_r <= 1'b0;
      ki_r <= OFS_MINUS;
      kj_r <= OFS_MINUS;
      kk_r <= OFS_MINUS;
    end else if (en) begin
      if (!seq_busy_r || seq_last) begin
        seq_busy_r <= in_take;
        ki_r <= OFS_MINUS;
        kj_r <= OFS_MINUS;
        kk_r <= OFS_MINUS;
      end else if (kk_r != OFS_PLUS) begin
        kk_r <= kk_r + 2'd1;
      end else begin
        kk_r <= OFS_MINUS;
        if (kj_r != OFS_PLUS) begin
          kj_r <= kj_r + 2'd1;
        end else begin
          kj_r <= OFS_MINUS;
          ki_r <= ki_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_take) begin
      bx_r <= {in_point_x[CW-1], in_point_x} - {cen_x_r[CW-1], cen_x_r};
      by_r <= {in_point_y[CW-1], in_point_y} - {cen_y_r[CW-1], cen_y_r};
      bz_r <= {in_point_z[CW-1], in_point_z} - {cen_z_r[CW-1], cen_z_r};
    end
  end

  function automatic logic [DW-1:0] img_ofs(input logic [BW-1:0] b,
                                            input logic [1:0] k,
                                            input logic [CW-2:0] per);
    logic [DW-1:0] be, pe;
    be = {b[BW-1], b};
    pe = {3'b000, per};
    case (k)
      OFS_MINUS: img_ofs = be - pe;
      OFS_PLUS:  img_ofs = be + pe;
      default:   img_ofs = be;
    endcase
  endfunction

  function automatic logic [MW-1:0] mag_of(input logic [DW-1:0] d);
    logic [DW-1:0] n;
    n = d[DW-1] ? (~d + DW'(1)) : d;
    mag_of = n[MW-1:0];
  endfunction

  // stage 1: image offsets
  logic [DW-1:0] s1_dx_r, s1_dy_r, s1_dz_r;
  term_tag_t     s1_tag_r, s1_tag_nxt;
  logic [1:0]    nz_cnt;

  always_comb begin
    nz_cnt = 2'((ki_r != OFS_NONE)) + 2'((kj_r != OFS_NONE)) + 2'((kk_r != OFS_NONE));
    s1_tag_nxt        = '0;
    s1_tag_nxt.vld    = seq_busy_r;
    s1_tag_nxt.add    = nz_cnt[0];
    s1_tag_nxt.first  = (ki_r == OFS_MINUS) && (kj_r == OFS_MINUS) && (kk_r == OFS_MINUS);
    s1_tag_nxt.last   = seq_last;
    s1_tag_nxt.centre = (nz_cnt == 2'd0);
  end

  // stage 2: squares, stage 3: squared distance
  logic [SQW-1:0] s2_qx_r, s2_qy_r, s2_qz_r;
  term_tag_t      s2_tag_r;
  logic [SW2-1:0] s3_s_r;
  term_tag_t      s3_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
      s2_tag_r <= '0;
      s3_tag_r <= '0;
    end else if (en) begin
      s1_tag_r <= s1_tag_nxt;
      s2_tag_r <= s1_tag_r;
      s3_tag_r <= s2_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx_r <= img_ofs(bx_r, ki_r, per_x_r);
      s1_dy_r <= img_ofs(by_r, kj_r, per_y_r);
      s1_dz_r <= img_ofs(bz_r, kk_r, per_z_r);
      s2_qx_r <= mag_of(s1_dx_r) * mag_of(s1_dx_r);
      s2_qy_r <= mag_of(s1_dy_r) * mag_of(s1_dy_r);
      s2_qz_r <= mag_of(s1_dz_r) * mag_of(s1_dz_r);
      s3_s_r  <= {2'b00, s2_qx_r} + {2'b00, s2_qy_r} + {2'b00, s2_qz_r};
    end
  end

  // square root, two radicand bits per stage
  function automatic logic [RMW+RW-1:0] rt_step(input logic [RMW-1:0] rem,
                                                input logic [RW-1:0] root,
                                                input logic [1:0] two);
    logic [RMW:0]  t;
    logic [RMW:0]  trial;
    logic [RW-1:0] nroot;
    t     = {rem[RMW-2:0], two};
    trial = {1'b0, root, 2'b01};
    if (t >= trial) begin
      t     = t - trial;
      nroot = {root[RW-2:0], 1'b1};
    end else begin
      nroot = {root[RW-2:0], 1'b0};
    end
    rt_step = {t[RMW-1:0], nroot};
  endfunction

  logic [RMW-1:0] rt_rem_r  [RW];
  logic [RW-1:0]  rt_root_r [RW];
  logic [SW2-1:0] rt_s_r    [RW];
  term_tag_t      rt_tag_r  [RW];
  logic [RMW-1:0] rt_rem_nxt  [RW];
  logic [RW-1:0]  rt_root_nxt [RW];
  logic [SW2-1:0] rt_s_nxt    [RW];
  term_tag_t      rt_tag_nxt  [RW];

  always_comb begin
    logic [RMW-1:0] ri;
    logic [RW-1:0]  oi;
    logic [SW2-1:0] si;
    term_tag_t      ti;
    for (int k = 0; k < RW; k++) begin
      if (k == 0) begin
        ri = '0;
        oi = '0;
        si = s3_s_r;
        ti = s3_tag_r;
        ti.interior = s3_tag_r.centre && (s3_s_r < SW2'(rr_r));
      end else begin
        ri = rt_rem_r[k-1];
        oi = rt_root_r[k-1];
        si = rt_s_r[k-1];
        ti = rt_tag_r[k-1];
      end
      {rt_rem_nxt[k], rt_root_nxt[k]} = rt_step(ri, oi, si[SW2-1:SW2-2]);
      rt_s_nxt[k]   = {si[SW2-3:0], 2'b00};
      rt_tag_nxt[k] = ti;
    end
  end

  // reciprocal, one quotient bit per stage
  logic [RW-1:0] dv_rem_r [QX];
  logic [QX-1:0] dv_q_r   [QX];
  logic [RW-1:0] dv_r_r   [QX];
  term_tag_t     dv_tag_r [QX];
  logic [RW-1:0] dv_rem_nxt [QX];
  logic [QX-1:0] dv_q_nxt   [QX];
  logic [RW-1:0] dv_r_nxt   [QX];
  term_tag_t     dv_tag_nxt [QX];

  always_comb begin
    logic [RW-1:0]  rmi, rvi;
    logic [QX-1:0]  qi;
    logic [RW:0]    t;
    logic           qb;
    term_tag_t      ti;
    logic [CPW-1:0] rsh;
    for (int k = 0; k < QX; k++) begin
      if (k == 0) begin
        rmi = '0;
        qi  = '0;
        rvi = rt_root_r[RW-1];
        ti  = rt_tag_r[RW-1];
        // quotient above the top positive value, zero distance included
        rsh = CPW'(rvi) << (CW - 1);
        ti.sat = rsh <= (CPW'(1) << (2 * FB));
      end else begin
        rmi = dv_rem_r[k-1];
        qi  = dv_q_r[k-1];
        rvi = dv_r_r[k-1];
        ti  = dv_tag_r[k-1];
        rsh = '0;
      end
      t  = {rmi, 1'((k == QX - 1 - 2 * FB))};
      qb = 1'b0;
      if (t >= {1'b0, rvi}) begin
        t  = t - {1'b0, rvi};
        qb = 1'b1;
      end
      dv_rem_nxt[k] = t[RW-1:0];
      dv_q_nxt[k]   = {qi[QX-2:0], qb};
      dv_r_nxt[k]   = rvi;
      dv_tag_nxt[k] = ti;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < RW; k++) rt_tag_r[k] <= '0;
      for (int k = 0; k < QX; k++) dv_tag_r[k] <= '0;
    end else if (en) begin
      for (int k = 0; k < RW; k++) rt_tag_r[k] <= rt_tag_nxt[k];
      for (int k = 0; k < QX; k++) dv_tag_r[k] <= dv_tag_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < RW; k++) begin
        rt_rem_r[k]  <= rt_rem_nxt[k];
        rt_root_r[k] <= rt_root_nxt[k];
        rt_s_r[k]    <= rt_s_nxt[k];
      end
      for (int k = 0; k < QX; k++) begin
        dv_rem_r[k] <= dv_rem_nxt[k];
        dv_q_r[k]   <= dv_q_nxt[k];
        dv_r_r[k]   <= dv_r_nxt[k];
      end
    end
  end

  // signed accumulation of the 27 terms
  term_tag_t     dt;
  logic [CW-2:0] tq;
  logic [ACW-1:0] ac_sum_r, ac_sum_nxt, ac_base;
  logic          ac_sat_r, ac_sat_nxt, ac_in_r, ac_in_nxt;
  logic          fn_vld_r;
  logic [ACW-1:0] fn_sum_r;
  logic          fn_sat_r, fn_in_r;

  assign dt = dv_tag_r[QX-1];
  assign tq = dt.sat ? QMAX : dv_q_r[QX-1][CW-2:0];

  always_comb begin
    ac_base    = dt.first ? '0 : ac_sum_r;
    ac_sum_nxt = dt.add ? ac_base + {6'd0, tq} : ac_base - {6'd0, tq};
    ac_sat_nxt = (!dt.first && ac_sat_r) || dt.sat;
    ac_in_nxt  = (!dt.first && ac_in_r) || dt.interior;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fn_vld_r <= 1'b0;
    end else if (en) begin
      fn_vld_r <= dt.vld && dt.last;
    end
  end

  always_ff @(posedge clk) begin
    if (en && dt.vld) begin
      ac_sum_r <= ac_sum_nxt;
      ac_sat_r <= ac_sat_nxt;
      ac_in_r  <= ac_in_nxt;
      fn_sum_r <= ac_sum_nxt;
      fn_sat_r <= ac_sat_nxt;
      fn_in_r  <= ac_in_nxt;
    end
  end

  // scaling by P*R: split product, then combine, then clamp
  logic [SMW-1:0]    smag;
  logic [ACW-1:0]    sneg;
  logic [PL+SMW-1:0] f1_lo_r;
  logic [PH+SMW-1:0] f1_hi_r;
  logic              f1_vld_r, f1_neg_r, f1_sat_r, f1_in_r;
  logic [PFW-1:0]    f2_prod_r;
  logic              f2_vld_r, f2_neg_r, f2_sat_r, f2_in_r;
  logic [PFW-1:0]    lim, clamped, full;
  logic              over;
  logic [CW-1:0]     res, pot_nxt;
  logic [CW-1:0]     out_pot_r;
  logic              out_sat_r;

  // freeze only when a finished result would overwrite one still held
  assign en = !(f2_vld_r && out_valid_r && out_stall);

  assign sneg = ~fn_sum_r + ACW'(1);
  assign smag = fn_sum_r[ACW-1] ? sneg[SMW-1:0] : fn_sum_r[SMW-1:0];
  assign full = PFW'(f1_lo_r) + (PFW'(f1_hi_r) << PL);

  always_comb begin
    lim     = f2_neg_r ? (PFW'(1) << (CW - 1)) : PFW'(QMAX);
    over    = f2_prod_r > lim;
    clamped = over ? lim : f2_prod_r;
    res     = clamped[CW-1:0];
    pot_nxt = f2_in_r ? pot_r : (f2_neg_r ? (~res + CW'(1)) : res);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r    <= 1'b0;
      f2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        f1_vld_r <= fn_vld_r;
        f2_vld_r <= f1_vld_r;
      end
      if (en && f2_vld_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_lo_r   <= pr_r[PL-1:0] * smag;
      f1_hi_r   <= pr_r[PRW-1:PL] * smag;
      f1_neg_r  <= !(pot_r[CW-1] != fn_sum_r[ACW-1]);
      f1_sat_r  <= fn_sat_r;
      f1_in_r   <= fn_in_r;
      f2_prod_r <= full >> FB;
      f2_neg_r  <= f1_neg_r;
      f2_sat_r  <= f1_sat_r;
      f2_in_r   <= f1_in_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && f2_vld_r) begin
      out_pot_r <= pot_nxt;
      out_sat_r <= !f2_in_r && (f2_sat_r || over);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_potential = out_pot_r;
  assign out_saturated = out_sat_r;

  // a new point only once the previous one has issued its last term
  a_issue_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> (!seq_busy_r || seq_last))
    else $error("point taken while terms still issuing");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(ac_sum_r) && $stable(fn_vld_r))
    else $error("pipeline moved under a stall");

  a_centre_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_tag_r.vld && s1_tag_r.centre) |-> !s1_tag_r.add)
    else $error("centre term must be subtracted");

  a_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_tag_r[0].vld && (dv_r_r[0] == '0)) |-> dv_tag_r[0].sat)
    else $error("zero distance not flagged");

endmodule
